@@ rtl/rwa_pkg.sv @@
// ----------------------------------------------------------------------------
// rwa_pkg
// Types and constants for the windowed RMS accumulator.
// ----------------------------------------------------------------------------
package rwa_pkg;

    localparam int MAX_SAMPLES = 1024;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int SQ_W     = 2 * SAMPLE_W - 1;
    localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W    = SQ_W + CNT_W - 1;
    localparam int QUO_W    = (SUM_W > 32) ? SUM_W : 32;
    localparam int STEP_W   = $clog2(QUO_W + 1);
    localparam int ROOT_W   = 16;
    localparam int UNIT_W   = ROOT_W + 3;
    localparam int RMS_W    = 15;
    localparam int OCNT_W   = 11;
    localparam int SQRT_STEPS = ROOT_W;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first;
        logic                       last;
    } t_rwa_in;

    typedef struct packed {
        logic [RMS_W-1:0]  rms;
        logic [OCNT_W-1:0] sample_count;
    } t_rwa_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DIV,
        S_SQRT,
        S_DONE
    } t_rwa_state;

endpackage

@@ rtl/rms_window_accumulator.sv @@
// ----------------------------------------------------------------------------
// rms_window_accumulator
// Sum of squares over a sample window; on the last sample, iterative
// restoring divide by the count and digit-by-digit square root on one
// shared compare/subtract unit.
// ----------------------------------------------------------------------------
//  channel | signals                             | payload
//  --------+-------------------------------------+------------------
//  input   | i_in_valid / o_in_ready / i_in_data | sample, first, last
//  output  | o_out_valid / i_out_ready / o_out_data | rms, sample_count
//
//  A sample without last is accepted in idle and accumulated in S_ADD. A
//  last-marked sample then runs QUO_W divide steps and 16 root steps on
//  the shared divider/root subtractor before its result is registered; no
//  new sample is accepted until the block is back in idle.
//  Reset is synchronous, active low, and clears sum, count and handshakes.
//  The result sits in an output register; the block waits in its final
//  state only if a previous result has not been taken.
// ----------------------------------------------------------------------------
module rms_window_accumulator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rwa_pkg::t_rwa_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rwa_pkg::t_rwa_out o_out_data
);
    import rwa_pkg::*;

    t_rwa_state         r_state, n_state;
    logic [SQ_W-1:0]    r_sq;
    logic               r_first;
    logic               r_last;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [QUO_W-1:0]   r_quo, n_quo;
    logic [UNIT_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_out_valid, n_out_valid;
    t_rwa_out           r_out, n_out;

    logic [MAG_W-1:0]   w_ext;
    logic [MAG_W-1:0]   w_mag;
    logic [2*MAG_W-1:0] w_sq_full;
    logic               w_in_acc;
    logic               w_out_free;

    logic [UNIT_W-1:0]  w_a, w_b, w_diff;
    logic               w_ge;
    logic [63:0]        w_cnt_ext;

    assign w_ext     = {i_in_data.sample[SAMPLE_W-1], i_in_data.sample};
    assign w_mag     = w_ext[MAG_W-1] ? (~w_ext + MAG_W'(1)) : w_ext;
    assign w_sq_full = w_mag * w_mag;
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_cnt_ext = 64'(r_count);

    // shared compare/subtract unit
    assign w_ge   = (w_a >= w_b);
    assign w_diff = w_a - w_b;

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_state)
            S_DIV: begin
                w_a = {r_rem[UNIT_W-2:0], r_quo[QUO_W-1]};
                w_b = UNIT_W'(r_count);
            end
            S_SQRT: begin
                w_a = {r_rem[UNIT_W-3:0], r_quo[QUO_W-1 -: 2]};
                w_b = UNIT_W'({r_root, 2'b01});
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_count     = r_count;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_root      = r_root;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_in_ready  = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (w_in_acc) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if (r_first) begin
                    n_sum   = '0;
                    n_count = '0;
                end
                if (n_count < CNT_W'(MAX_SAMPLES)) begin
                    n_sum   = n_sum + SUM_W'(r_sq);
                    n_count = n_count + CNT_W'(1);
                end
                if (r_last) begin
                    n_quo   = QUO_W'(n_sum);
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                n_rem  = w_ge ? w_diff : w_a;
                n_quo  = {r_quo[QUO_W-2:0], w_ge};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(QUO_W - 1)) begin
                    n_quo   = QUO_W'({{(32-SQ_W){1'b0}}, n_quo[SQ_W-1:0]}) << (QUO_W - 32);
                    n_rem   = '0;
                    n_root  = '0;
                    n_step  = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                n_rem  = w_ge ? w_diff : w_a;
                n_root = {r_root[ROOT_W-2:0], w_ge};
                n_quo  = r_quo << 2;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_count == '0) begin
                        n_out.rms = '0;
                    end else if (r_root[ROOT_W-1]) begin
                        n_out.rms = '1;
                    end else begin
                        n_out.rms = r_root[RMS_W-1:0];
                    end
                    n_out.sample_count = w_cnt_ext[OCNT_W-1:0];
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sq    <= w_sq_full[SQ_W-1:0];
            r_first <= i_in_data.first;
            r_last  <= i_in_data.last;
        end
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_step <= n_step;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
